// ===== design/mlprq_pkg.sv =====
// Shared types and constants of the multilevel priority run queue.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package mlprq_pkg;

    // Fixed field widths of the item formats
    localparam int TASK_W  = 6;
    localparam int PRIO_W  = 5;
    localparam int COUNT_W = 7;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_REQUEUE = 2'd2,
        MODE_NEXT    = 2'd3
    } mode_t;

    // Command broadcast along the chain of cells
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_LOOKUP = 3'd1,
        ST_DELETE = 3'd2,
        ST_INSERT = 3'd3,
        ST_RESP   = 3'd4
    } state_t;

    typedef struct packed {
        mode_t               mode;
        logic [TASK_W-1:0]   task_id;
        logic [PRIO_W-1:0]   priority_req;
    } in_item_t;

    typedef struct packed {
        logic [TASK_W-1:0]   selected_task;
        logic                is_idle;
        logic [COUNT_W-1:0]  queued_count;
        logic                op_error;
    } out_item_t;

endpackage

// ===== design/mlprq_cell.sv =====
// One slot of the sorted run-queue chain: holds a task and its level.
// Depends on mlprq_pkg; instantiated in a row by multilevel_priority_run_queue_top.
`timescale 1ns / 1ps

module mlprq_cell #(
    parameter int LVL_W = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlprq_pkg::cell_op_t           cmd,
    input  logic [mlprq_pkg::TASK_W-1:0]  key_tid,
    input  logic [LVL_W-1:0]              key_level,
    // left neighbour (towards the head)
    input  logic                          left_valid,
    input  logic [mlprq_pkg::TASK_W-1:0]  left_tid,
    input  logic [LVL_W-1:0]              left_level,
    input  logic                          left_le,
    // right neighbour (towards the tail)
    input  logic                          right_valid,
    input  logic [mlprq_pkg::TASK_W-1:0]  right_tid,
    input  logic [LVL_W-1:0]              right_level,
    input  logic                          take_right,
    output logic                          valid,
    output logic [mlprq_pkg::TASK_W-1:0]  tid,
    output logic [LVL_W-1:0]              level,
    output logic                          le,
    output logic                          match
);

    logic                          valid_reg;
    logic [mlprq_pkg::TASK_W-1:0]  tid_reg;
    logic [LVL_W-1:0]              level_reg;

    // Entry sits at or before the insertion point of key_level
    assign le    = valid_reg && (level_reg <= key_level);
    assign match = valid_reg && (tid_reg == key_tid);
    assign valid = valid_reg;
    assign tid   = tid_reg;
    assign level = level_reg;

    // Occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (cmd)
                mlprq_pkg::CELL_INSERT: begin
                    if (!le) begin
                        valid_reg <= left_le ? 1'b1 : left_valid;
                    end
                end
                mlprq_pkg::CELL_DELETE: begin
                    if (take_right) begin
                        valid_reg <= right_valid;
                    end
                end
                default: ;
            endcase
        end
    end

    // Entry payload: new item at the insertion point, shift otherwise
    always_ff @(posedge aclk) begin
        case (cmd)
            mlprq_pkg::CELL_INSERT: begin
                if (!le) begin
                    if (left_le) begin
                        tid_reg   <= key_tid;
                        level_reg <= key_level;
                    end else begin
                        tid_reg   <= left_tid;
                        level_reg <= left_level;
                    end
                end
            end
            mlprq_pkg::CELL_DELETE: begin
                if (take_right) begin
                    tid_reg   <= right_tid;
                    level_reg <= right_level;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/multilevel_priority_run_queue_top.sv =====
// Top level of the multilevel priority run queue: sequencer, count and ports.
// Depends on mlprq_pkg and mlprq_cell.
//
//  Channel   Direction  Ports                          Payload
//  ------    ---------  -----------------------------  -------------------
//  input     in         s_valid, s_ready, s_data       mlprq_pkg::in_item_t
//  result    out        m_valid, m_ready, m_data       mlprq_pkg::out_item_t
//  config    in         cfg_valid, cfg_ready, cfg_data fallback task id, 6 bits
//
// Queued tasks sit in a chain of cells sorted by level, FIFO order within a
// level, so the head cell, when occupied, is the task next returns.
// Each item passes accept, lookup and respond; add and remove put one chain
// shift before respond, requeue a delete shift then an insert shift.
// The result register frees the input side; RESP holds while it is full.
// Synchronous active-low reset empties the chain at once; cfg_ready is always high.
`timescale 1ns / 1ps

module multilevel_priority_run_queue_top #(
    parameter int NUM_LEVELS = 32,
    parameter int NUM_TASKS  = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mlprq_pkg::in_item_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mlprq_pkg::out_item_t          m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mlprq_pkg::TASK_W-1:0]  cfg_data
);

    localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);

    mlprq_pkg::state_t              state_reg, state_next;
    mlprq_pkg::mode_t               mode_reg;
    logic [mlprq_pkg::TASK_W-1:0]   tid_reg;
    logic [LVL_W-1:0]               lvl_reg;
    logic [NUM_TASKS-1:0]           match_reg;
    logic                           err_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [mlprq_pkg::TASK_W-1:0]   fallback_tid_reg;
    logic                           out_valid_reg;
    mlprq_pkg::out_item_t           out_data_reg;

    logic                           load_op, load_lookup, load_out;
    mlprq_pkg::cell_op_t            cell_cmd;
    logic [LVL_W-1:0]               sat_level;
    logic [LVL_W-1:0]               match_lvl;
    logic                           queued, tid_ok, lookup_err;
    logic [NUM_TASKS-1:0]           del_mask;

    logic [NUM_TASKS-1:0]           cell_valid, cell_le, match_vec;
    logic [mlprq_pkg::TASK_W-1:0]   cell_tid [NUM_TASKS];
    logic [LVL_W-1:0]               cell_lvl [NUM_TASKS];

    // Chain of cells, head at index 0
    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
        logic                           l_valid, l_le, r_valid;
        logic [mlprq_pkg::TASK_W-1:0]   l_tid, r_tid;
        logic [LVL_W-1:0]               l_lvl, r_lvl;

        if (i == 0) begin : g_head
            assign l_valid = 1'b1;
            assign l_tid   = '0;
            assign l_lvl   = '0;
            assign l_le    = 1'b1;
        end else begin : g_mid
            assign l_valid = cell_valid[i-1];
            assign l_tid   = cell_tid[i-1];
            assign l_lvl   = cell_lvl[i-1];
            assign l_le    = cell_le[i-1];
        end

        if (i == NUM_TASKS - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_tid   = '0;
            assign r_lvl   = '0;
        end else begin : g_body
            assign r_valid = cell_valid[i+1];
            assign r_tid   = cell_tid[i+1];
            assign r_lvl   = cell_lvl[i+1];
        end

        mlprq_cell #(
            .LVL_W (LVL_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cell_cmd),
            .key_tid     (tid_reg),
            .key_level   (lvl_reg),
            .left_valid  (l_valid),
            .left_tid    (l_tid),
            .left_level  (l_lvl),
            .left_le     (l_le),
            .right_valid (r_valid),
            .right_tid   (r_tid),
            .right_level (r_lvl),
            .take_right  (del_mask[i]),
            .valid       (cell_valid[i]),
            .tid         (cell_tid[i]),
            .level       (cell_lvl[i]),
            .le          (cell_le[i]),
            .match       (match_vec[i])
        );
    end

    // Priority saturated to the top level
    always_comb begin
        if (32'(s_data.priority_req) >= NUM_LEVELS) begin
            sat_level = LVL_W'(NUM_LEVELS - 1);
        end else begin
            sat_level = LVL_W'(s_data.priority_req);
        end
    end

    // Level of the matched task (at most one cell matches)
    always_comb begin
        match_lvl = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            match_lvl = match_lvl | ({LVL_W{match_vec[i]}} & cell_lvl[i]);
        end
    end

    assign tid_ok = (32'(tid_reg) < NUM_TASKS);
    assign queued = tid_ok && (|match_vec);

    always_comb begin
        case (mode_reg)
            mlprq_pkg::MODE_ADD:     lookup_err = !tid_ok || queued;
            mlprq_pkg::MODE_REMOVE,
            mlprq_pkg::MODE_REQUEUE: lookup_err = !queued;
            default:                 lookup_err = 1'b0;
        endcase
    end

    // Cells from the removed one to the tail shift towards the head
    assign del_mask = (state_reg == mlprq_pkg::ST_DELETE) ?
                      ~(match_reg - NUM_TASKS'(1)) : '0;

    // Sequencer: next state and controls
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cell_cmd    = mlprq_pkg::CELL_HOLD;
        load_op     = 1'b0;
        load_lookup = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            mlprq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    load_op    = 1'b1;
                    state_next = mlprq_pkg::ST_LOOKUP;
                end
            end
            mlprq_pkg::ST_LOOKUP: begin
                load_lookup = 1'b1;
                if (lookup_err || mode_reg == mlprq_pkg::MODE_NEXT) begin
                    state_next = mlprq_pkg::ST_RESP;
                end else if (mode_reg == mlprq_pkg::MODE_ADD) begin
                    state_next = mlprq_pkg::ST_INSERT;
                end else begin
                    state_next = mlprq_pkg::ST_DELETE;
                end
            end
            mlprq_pkg::ST_DELETE: begin
                cell_cmd   = mlprq_pkg::CELL_DELETE;
                state_next = (mode_reg == mlprq_pkg::MODE_REQUEUE) ?
                             mlprq_pkg::ST_INSERT : mlprq_pkg::ST_RESP;
            end
            mlprq_pkg::ST_INSERT: begin
                cell_cmd   = mlprq_pkg::CELL_INSERT;
                state_next = mlprq_pkg::ST_RESP;
            end
            mlprq_pkg::ST_RESP: begin
                if (!out_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = mlprq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mlprq_pkg::ST_IDLE;
            end
        endcase
    end

    // State, count, result handshake and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= mlprq_pkg::ST_IDLE;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            fallback_tid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == mlprq_pkg::ST_INSERT && mode_reg == mlprq_pkg::MODE_ADD) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (state_reg == mlprq_pkg::ST_DELETE &&
                         mode_reg == mlprq_pkg::MODE_REMOVE) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                fallback_tid_reg <= cfg_data;
            end
        end
    end

    // Operation and lookup registers
    always_ff @(posedge aclk) begin
        if (load_op) begin
            mode_reg <= s_data.mode;
            tid_reg  <= s_data.task_id;
            lvl_reg  <= sat_level;
        end
        if (load_lookup) begin
            match_reg <= match_vec;
            err_reg   <= lookup_err;
            if (mode_reg == mlprq_pkg::MODE_REQUEUE) begin
                lvl_reg <= match_lvl;
            end
        end
    end

    // Result item, taken from the chain head for next
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg.queued_count <= mlprq_pkg::COUNT_W'(cnt_reg);
            out_data_reg.op_error     <= err_reg;
            if (mode_reg == mlprq_pkg::MODE_NEXT) begin
                out_data_reg.selected_task <= cell_valid[0] ? cell_tid[0] : fallback_tid_reg;
                out_data_reg.is_idle       <= !cell_valid[0];
            end else begin
                out_data_reg.selected_task <= '0;
                out_data_reg.is_idle       <= 1'b0;
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    // Task count tracks the occupied cells; a requeued task is out of the
    // chain between its delete and insert shifts
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlprq_pkg::ST_INSERT && mode_reg == mlprq_pkg::MODE_REQUEUE) ?
        (32'(cnt_reg) == $countones(cell_valid) + 1) :
        (32'(cnt_reg) == $countones(cell_valid)))
        else $error("queued count differs from occupied cells");

    // Occupied cells form an unbroken run from the head
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid & (cell_valid + NUM_TASKS'(1))) == '0)
        else $error("hole in the cell chain");

    // A task is held by at most one cell
    a_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("task held by more than one cell");

    // A delete shift always has a matched cell
    a_delete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlprq_pkg::ST_DELETE) |-> (match_reg != '0))
        else $error("delete shift without a matched task");
`endif

endmodule
